/* src/oer_pkg.sv */
`timescale 1ns / 1ps
// Shared constants and codes of the overwriting event ring.
package oer_pkg;

    localparam int CAP_W  = 7;
    localparam int DATA_W = 32;
    localparam int DROP_W = 32;
    localparam int KIND_W = 2;
    localparam int REQ_W  = 8;

    localparam logic [CAP_W-1:0]  RESULT_LIMIT = 7'd64;
    localparam logic [CAP_W-1:0]  CAP_RESET    = 7'd64;
    localparam logic [DROP_W-1:0] DROP_MAX     = 32'hFFFF_FFFF;

    localparam logic OP_PUSH  = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    localparam logic [KIND_W-1:0] KIND_PUSH  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_EVENT = 2'd1;
    localparam logic [KIND_W-1:0] KIND_EMPTY = 2'd2;

endpackage

/* src/oer_if.sv */
`timescale 1ns / 1ps
// Request, result and capacity write channels of the event ring.
interface oer_cmd_if;
    logic              valid;
    logic              ready;
    logic              op;
    logic [31:0]       event_data;
    logic signed [7:0] drain_max;

    modport source (output valid, op, event_data, drain_max, input ready);
    modport sink   (input valid, op, event_data, drain_max, output ready);
    modport mon    (input valid, ready, op, event_data, drain_max);
endinterface

interface oer_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [31:0] event_data_out;
    logic        accepted;
    logic        last;
    logic [6:0]  fill_level;
    logic [31:0] drop_count;

    modport source (output valid, kind, event_data_out, accepted, last, fill_level,
                    drop_count, input ready);
    modport sink   (input valid, kind, event_data_out, accepted, last, fill_level,
                    drop_count, output ready);
    modport mon    (input valid, ready, kind, event_data_out, accepted, last,
                    fill_level, drop_count);
endinterface

interface oer_cfg_if;
    logic       valid;
    logic       ready;
    logic [6:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
    modport mon    (input valid, ready, data);
endinterface

/* src/oer_ram.sv */
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module oer_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* src/oer_wrap_unit.sv */
`timescale 1ns / 1ps
// Shared modular adder: (a + b) mod cap for a below cap and b at most cap.
module oer_wrap_unit
    import oer_pkg::*;
(
    input  logic [CAP_W-1:0] a,
    input  logic [CAP_W-1:0] b,
    input  logic [CAP_W-1:0] cap,
    output logic [CAP_W-1:0] y
);

    logic [CAP_W:0] sum;
    logic [CAP_W:0] diff;

    assign sum  = {1'b0, a} + {1'b0, b};
    assign diff = sum - {1'b0, cap};
    assign y    = (sum >= {1'b0, cap}) ? diff[CAP_W-1:0] : sum[CAP_W-1:0];

endmodule

/* src/oer_seq.sv */
`timescale 1ns / 1ps
// Sequencer of the event ring: pointers, fill level, drop count and result register.
module oer_seq
    import oer_pkg::*;
#(
    parameter int SW = 32,
    parameter int AW = 6
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [CAP_W-1:0] cap,
    input  logic             clear,
    oer_cmd_if.sink          cmd,
    oer_rsp_if.source        rsp,
    output logic             ram_we,
    output logic [AW-1:0]    ram_waddr,
    output logic [SW-1:0]    ram_wdata,
    output logic             ram_re,
    output logic [AW-1:0]    ram_raddr,
    input  logic [SW-1:0]    ram_rdata
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PUSH  = 3'd1;
    localparam logic [2:0] S_DRAIN = 3'd2;
    localparam logic [2:0] S_READ  = 3'd3;
    localparam logic [2:0] S_EMIT  = 3'd4;

    logic [2:0]        state_reg, state_next;
    logic              op_reg, op_next;
    logic [SW-1:0]     data_reg, data_next;
    logic [CAP_W-1:0]  want_reg, want_next;
    logic [CAP_W-1:0]  head_reg, head_next;
    logic [CAP_W-1:0]  held_reg, held_next;
    logic [DROP_W-1:0] drop_reg, drop_next;
    logic [CAP_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CAP_W-1:0]  remain_reg, remain_next;

    logic              out_valid_reg, out_valid_next;
    logic [KIND_W-1:0] kind_reg, kind_next;
    logic [DATA_W-1:0] out_data_reg, out_data_next;
    logic              acc_reg, acc_next;
    logic              last_reg, last_next;
    logic [CAP_W-1:0]  fill_reg, fill_next;
    logic [DROP_W-1:0] cnt_reg, cnt_next;

    logic [CAP_W-1:0]  unit_a, unit_b, unit_y;
    logic              full;
    logic              space;
    logic [CAP_W-1:0]  taken_held, taken;
    logic [CAP_W-1:0]  tail;
    logic [DROP_W-1:0] drop_inc;

    oer_wrap_unit u_wrap (
        .a   (unit_a),
        .b   (unit_b),
        .cap (cap),
        .y   (unit_y)
    );

    assign full       = (held_reg >= cap);
    assign space      = !out_valid_reg || rsp.ready;
    assign taken_held = (want_reg < held_reg) ? want_reg : held_reg;
    assign taken      = (taken_held > RESULT_LIMIT) ? RESULT_LIMIT : taken_held;
    assign tail       = full ? head_reg : unit_y;
    assign drop_inc   = (drop_reg == DROP_MAX) ? drop_reg : drop_reg + 32'd1;

    assign cmd.ready          = (state_reg == S_IDLE);
    assign rsp.valid          = out_valid_reg;
    assign rsp.kind           = kind_reg;
    assign rsp.event_data_out = out_data_reg;
    assign rsp.accepted       = acc_reg;
    assign rsp.last           = last_reg;
    assign rsp.fill_level     = fill_reg;
    assign rsp.drop_count     = cnt_reg;

    assign ram_waddr = AW'(tail);
    assign ram_wdata = data_reg;
    assign ram_raddr = AW'(rd_ptr_reg);

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        data_next      = data_reg;
        want_next      = want_reg;
        head_next      = head_reg;
        held_next      = held_reg;
        drop_next      = drop_reg;
        rd_ptr_next    = rd_ptr_reg;
        remain_next    = remain_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        kind_next      = kind_reg;
        out_data_next  = out_data_reg;
        acc_next       = acc_reg;
        last_next      = last_reg;
        fill_next      = fill_reg;
        cnt_next       = cnt_reg;
        unit_a         = rd_ptr_reg;
        unit_b         = 7'd1;
        ram_we         = 1'b0;
        ram_re         = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd.valid)
                begin
                    op_next    = cmd.op;
                    data_next  = cmd.event_data[SW-1:0];
                    want_next  = cmd.drain_max[7] ? 7'd0 : cmd.drain_max[6:0];
                    state_next = (cmd.op == OP_PUSH) ? S_PUSH : S_DRAIN;
                end
            end
            S_PUSH:
            begin
                unit_a = head_reg;
                unit_b = full ? 7'd1 : held_reg;
                if (space)
                begin
                    ram_we         = 1'b1;
                    out_valid_next = 1'b1;
                    kind_next      = KIND_PUSH;
                    out_data_next  = '0;
                    last_next      = 1'b1;
                    if (full)
                    begin
                        head_next = unit_y;
                        drop_next = drop_inc;
                        acc_next  = 1'b0;
                        fill_next = held_reg;
                        cnt_next  = drop_inc;
                    end
                    else
                    begin
                        held_next = held_reg + 7'd1;
                        acc_next  = 1'b1;
                        fill_next = held_reg + 7'd1;
                        cnt_next  = drop_reg;
                    end
                    state_next = S_IDLE;
                end
            end
            S_DRAIN:
            begin
                if (taken == 7'd0)
                begin
                    if (space)
                    begin
                        out_valid_next = 1'b1;
                        kind_next      = KIND_EMPTY;
                        out_data_next  = '0;
                        acc_next       = 1'b0;
                        last_next      = 1'b1;
                        fill_next      = held_reg;
                        cnt_next       = drop_reg;
                        state_next     = S_IDLE;
                    end
                end
                else
                begin
                    held_next   = held_reg - taken;
                    remain_next = taken;
                    rd_ptr_next = head_reg;
                    state_next  = S_READ;
                end
            end
            S_READ:
            begin
                ram_re      = 1'b1;
                rd_ptr_next = unit_y;
                state_next  = S_EMIT;
            end
            S_EMIT:
            begin
                if (space)
                begin
                    out_valid_next = 1'b1;
                    kind_next      = KIND_EVENT;
                    out_data_next  = DATA_W'(ram_rdata);
                    acc_next       = 1'b0;
                    last_next      = (remain_reg == 7'd1);
                    fill_next      = held_reg;
                    cnt_next       = drop_reg;
                    remain_next    = remain_reg - 7'd1;
                    if (remain_reg == 7'd1)
                    begin
                        head_next  = rd_ptr_reg;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_READ;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // empty the ring on a capacity write
        if (clear)
        begin
            head_next = '0;
            held_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            held_reg      <= '0;
            drop_reg      <= '0;
            remain_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            held_reg      <= held_next;
            drop_reg      <= drop_next;
            remain_reg    <= remain_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        data_reg     <= data_next;
        want_reg     <= want_next;
        rd_ptr_reg   <= rd_ptr_next;
        kind_reg     <= kind_next;
        out_data_reg <= out_data_next;
        acc_reg      <= acc_next;
        last_reg     <= last_next;
        fill_reg     <= fill_next;
        cnt_reg      <= cnt_next;
    end

endmodule

/* src/overwriting_event_ring_top.sv */
`timescale 1ns / 1ps
// Top level of the overwriting event ring.
//
// Channels: cmd takes one request (push an event, or drain up to drain_max
// events), rsp returns results, cfg writes the ring capacity. All use
// valid/ready; a transfer happens on a rising edge with both high.
// A push returns one acknowledge; accepted is low when the ring was full and
// the oldest entry was overwritten. A drain returns the oldest events in order,
// last marking the final one, or one empty result when nothing is taken.
// A push or empty-drain result is registered in the push or drain state that
// follows the taken request, and the block then returns to idle. A drain that
// takes events goes through a setup state, then read and emit per event, set by
// the registered slot RAM read and the shared modular adder stepping the pointer.
// One request is worked on at a time; cmd.ready rises once the last result
// is in the output register, so the next request is taken while it waits.
// A stalled rsp.ready holds the result register and the sequencer waits.
// Reset empties the ring, clears the drop count and sets the capacity to 64;
// slot contents are not cleared. A capacity write empties the ring and keeps
// the drop count; write it only while the block is idle.
module overwriting_event_ring_top
    import oer_pkg::*;
#(
    parameter int DEPTH       = 64,
    parameter int EVENT_WIDTH = 32
) (
    input  logic      clk,
    input  logic      rst_n,
    oer_cfg_if.sink   cfg,
    oer_cmd_if.sink   cmd,
    oer_rsp_if.source rsp
);

    localparam int SW = (EVENT_WIDTH < DATA_W) ? EVENT_WIDTH : DATA_W;
    localparam int AW = $clog2(DEPTH);

    logic [CAP_W-1:0] cap_reg;
    logic [CAP_W-1:0] cap_eff;
    logic             cfg_write;

    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [SW-1:0]    ram_wdata;
    logic             ram_re;
    logic [AW-1:0]    ram_raddr;
    logic [SW-1:0]    ram_rdata;

    assign cfg.ready = 1'b1;
    assign cfg_write = cfg.valid && cfg.ready;

    // clamp capacity to 1..DEPTH
    assign cap_eff = (cap_reg == 7'd0) ? 7'd1 :
                     (32'(cap_reg) > 32'(DEPTH)) ? CAP_W'(DEPTH) : cap_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAP_RESET;
        end
        else if (cfg_write)
        begin
            cap_reg <= cfg.data;
        end
    end

    oer_seq #(
        .SW (SW),
        .AW (AW)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cap       (cap_eff),
        .clear     (cfg_write),
        .cmd       (cmd),
        .rsp       (rsp),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    oer_ram #(
        .WIDTH (SW),
        .DEPTH (DEPTH)
    ) u_slots (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule

/* src/oer_checker.sv */
`timescale 1ns / 1ps
// Port-level assertions of the event ring and their binding to the top level.
module oer_checker
    import oer_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    oer_cmd_if.sink   cmd,
    oer_rsp_if.source rsp
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.kind)
            && $stable(rsp.event_data_out) && $stable(rsp.last))
        else $error("result changed while stalled");

    a_no_req_mid_drain: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.kind == KIND_EVENT && !rsp.last |-> !cmd.ready)
        else $error("request taken before drain finished");

    a_accept_push_only: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.kind != KIND_PUSH |-> !rsp.accepted)
        else $error("accepted flag on a drain result");

    a_empty_shape: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && (rsp.kind == KIND_EMPTY || rsp.kind == KIND_PUSH)
            |-> rsp.last && rsp.event_data_out == '0)
        else $error("malformed single result");

endmodule

bind overwriting_event_ring_top oer_checker u_oer_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .rsp   (rsp)
);
